FILE: design/spectrum_smoother_band_averager_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the spectrum smoother band averager
// Immediate-consequence and next-cycle checks, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_SMOOTHER_BAND_AVERAGER_TOP_MACROS_SVH
`define SPECTRUM_SMOOTHER_BAND_AVERAGER_TOP_MACROS_SVH

`ifndef SYNTH
// Check that a condition implies another in the same cycle
`define SSBA_CHK_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ssba check failed");
// Check that a condition implies another in the next cycle
`define SSBA_CHK_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ssba check failed");
`else
`define SSBA_CHK_NOW(name, clk, rst_n, ante, cons)
`define SSBA_CHK_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/ssba_pkg.sv
// ----------------------------------------------------------------------------
// ssba_pkg
// Shared types and constants of the spectrum smoother band averager.
// ----------------------------------------------------------------------------
`default_nettype none

package ssba_pkg;

	// Fixed field widths
	localparam int CH_W     = 2;
	localparam int MAG_W    = 24;
	localparam int IDX_W    = 11;
	localparam int BIDX_W   = 10;
	localparam int OUT_W    = 24;
	localparam int BC_W     = 11;
	localparam int SM_W     = 16;
	localparam int CFG_IX_W = 1;
	localparam int CFG_D_W  = 16;

	// Register indexes
	localparam logic [CFG_IX_W-1:0] CFG_BIN_COUNT = 1'd0;
	localparam logic [CFG_IX_W-1:0] CFG_SMOOTHING = 1'd1;

	// Register reset values
	localparam logic [BC_W-1:0] BIN_COUNT_RST = 11'd512;
	localparam logic [SM_W-1:0] SMOOTHING_RST = 16'd55706;

	// Unity weight in Q1.16
	localparam logic [16:0] WEIGHT_ONE = 17'h10000;

	// Index limits
	localparam logic [IDX_W-1:0]  CNT_TOP = 11'd2047;
	localparam logic [BIDX_W-1:0] IDX_TOP = 10'd1023;

	// n/10 = (n*RECIP10)>>SHIFT_TENTH, 2n/5 = (n*RECIP10)>>SHIFT_TWO_FIFTH
	localparam logic [15:0] RECIP10         = 16'd52429;
	localparam int          SHIFT_TENTH     = 19;
	localparam int          SHIFT_TWO_FIFTH = 17;

	// Band codes
	localparam logic [1:0] BAND_LOW  = 2'd0;
	localparam logic [1:0] BAND_MID  = 2'd1;
	localparam logic [1:0] BAND_HIGH = 2'd2;

	// Queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPW    = 2;

	typedef struct packed {
		logic [CH_W-1:0]  channel;
		logic [IDX_W-1:0] bin_idx;
		logic [MAG_W-1:0] magnitude;
		logic             used;
		logic             last;
	} q_entry_t;

	typedef struct packed {
		logic [CH_W-1:0]   out_channel;
		logic [BIDX_W-1:0] bin_index;
		logic [OUT_W-1:0]  smoothed;
		logic              bin_used;
		logic              bands_valid;
		logic [OUT_W-1:0]  bass;
		logic [OUT_W-1:0]  mid;
		logic [OUT_W-1:0]  treble;
	} result_t;

	typedef struct packed {
		logic idle;
		logic dividing;
	} back_stat_t;

endpackage

`default_nettype wire

FILE: design/ssba_ram.sv
// ----------------------------------------------------------------------------
// ssba_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ssba_ram #(
	parameter int WIDTH  = 24,
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: design/ssba_fifo.sv
// ----------------------------------------------------------------------------
// ssba_fifo
// Short queue of classified bins between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module ssba_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire ssba_pkg::q_entry_t push_data,
	output logic                    full,
	input  wire logic               pop,
	output logic                    valid,
	output ssba_pkg::q_entry_t      pop_data
);

	import ssba_pkg::*;

	q_entry_t       mem_q [QDEPTH];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QPW:0]   cnt_q;

	assign full     = (cnt_q == (QPW+1)'(QDEPTH));
	assign valid    = (cnt_q != '0);
	assign pop_data = mem_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

FILE: design/ssba_front.sv
// ----------------------------------------------------------------------------
// ssba_front
// Takes input words, counts the bin index, latches the frame channel and
// marks each bin as used or unused before queueing it.
// ----------------------------------------------------------------------------
`default_nettype none

module ssba_front #(
	parameter int MAX_BINS = 1024
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [$clog2(MAX_BINS+1)-1:0]   n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [ssba_pkg::CH_W-1:0]       in_channel,
	input  wire logic [ssba_pkg::MAG_W-1:0]      in_magnitude,
	input  wire logic                            in_last,
	input  wire logic                            q_full,
	output logic                                 q_push,
	output ssba_pkg::q_entry_t                   q_data
);

	import ssba_pkg::*;

	localparam int NW = $clog2(MAX_BINS + 1);
	localparam int CW = (NW > IDX_W) ? NW : IDX_W;

	logic [IDX_W-1:0] cnt_q;
	logic [CH_W-1:0]  chan_q;
	logic [CH_W-1:0]  cur_chan;
	logic             first;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;
	assign first    = (cnt_q == '0);
	assign cur_chan = first ? in_channel : chan_q;

	// Classify the bin
	always_comb begin
		q_data.channel   = cur_chan;
		q_data.bin_idx   = cnt_q;
		q_data.magnitude = in_magnitude;
		q_data.used      = (CW'(cnt_q) < CW'(n));
		q_data.last      = in_last;
	end

	// Count bins and latch the channel on the first bin
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			chan_q <= '0;
		end else if (q_push) begin
			if (first) begin
				chan_q <= in_channel;
			end
			if (in_last) begin
				cnt_q <= '0;
			end else if (cnt_q < CNT_TOP) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/ssba_div.sv
// ----------------------------------------------------------------------------
// ssba_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ssba_div #(
	parameter int DW = 34,
	parameter int VW = 12
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic               done,
	output logic      [DW-1:0] quotient
);

	localparam int CNW = $clog2(DW);

	logic           busy_q;
	logic           done_q;
	logic [CNW-1:0] cnt_q;
	logic [VW-1:0]  rem_q;
	logic [VW-1:0]  dsr_q;
	logic [DW-1:0]  quo_q;
	logic [VW:0]    trial;
	logic           fits;

	assign trial    = {rem_q, quo_q[DW-1]};
	assign fits     = (trial >= {1'b0, dsr_q});
	assign done     = done_q;
	assign quotient = quo_q;

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift in one dividend bit, subtract where the divisor fits
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? VW'(trial - {1'b0, dsr_q}) : trial[VW-1:0];
		end
	end

endmodule

`default_nettype wire

FILE: design/ssba_back.sv
// ----------------------------------------------------------------------------
// ssba_back
// Smooths queued bins into the per-channel store, walks the store at frame
// end to form the band sums and divides them into band averages.
// ----------------------------------------------------------------------------
`default_nettype none

module ssba_back #(
	parameter int MAX_BINS    = 1024,
	parameter int CHANNELS    = 4,
	parameter int SAMPLE_BITS = 24
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [$clog2(MAX_BINS+1)-1:0] n,
	input  wire logic [ssba_pkg::SM_W-1:0]     smoothing,
	input  wire logic                          q_valid,
	input  wire ssba_pkg::q_entry_t            q_data,
	output logic                               q_pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output ssba_pkg::result_t                  out_data,
	output ssba_pkg::back_stat_t               stat
);

	import ssba_pkg::*;

	localparam int NW   = $clog2(MAX_BINS + 1);
	localparam int CHW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int AW   = $clog2(CHANNELS * MAX_BINS);
	localparam int SB   = SAMPLE_BITS;
	localparam int PW   = SB + 19;
	localparam int SUMW = SB + $clog2(MAX_BINS);
	localparam int VW   = NW + 1;
	localparam int RW   = NW + 16;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD    = 4'd1;
	localparam logic [3:0] S_MUL   = 4'd2;
	localparam logic [3:0] S_WR    = 4'd3;
	localparam logic [3:0] S_PREP  = 4'd4;
	localparam logic [3:0] S_WALK  = 4'd5;
	localparam logic [3:0] S_DIVGO = 4'd6;
	localparam logic [3:0] S_DIVW  = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;

	// Reduce a channel number modulo the channel count
	function automatic logic [CHW-1:0] chan_sel(input logic [CH_W-1:0] c);
		logic [4:0] v;
		v = {3'b000, c};
		for (int k = 0; k < 3; k++) begin
			if (v >= 5'(CHANNELS)) begin
				v = v - 5'(CHANNELS);
			end
		end
		return CHW'(v);
	endfunction

	logic [3:0]       state_q;
	logic [3:0]       state_d;
	q_entry_t         ent_q;
	logic [CHW-1:0]   chs_q;
	logic [AW-1:0]    base_q;
	logic [AW-1:0]    addr_q;
	logic             old_ok_q;
	logic [NW-1:0]    hwm_q [CHANNELS];
	logic [NW-1:0]    hwm_cur;
	logic [SB-1:0]    old_s1;
	logic signed [PW-1:0] prod_s1;

	logic [NW-1:0]    walk_i_q;
	logic [NW-1:0]    bass_end_q;
	logic [NW-1:0]    mid_end_q;
	logic             wv_s1;
	logic             live_s1;
	logic [1:0]       band_s1;
	logic [SUMW-1:0]  low_sum_q;
	logic [SUMW-1:0]  mid_sum_q;
	logic [SUMW-1:0]  high_sum_q;
	logic [1:0]       div_sel_q;

	logic             out_valid_q;
	result_t          out_q;

	logic [AW-1:0]    item_addr;
	logic             walk_issue;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic             ram_we;
	logic [SB-1:0]    ram_rdata;
	logic [SB-1:0]    x_val;
	logic [SB-1:0]    old_val;
	logic signed [SB:0]   diff;
	logic signed [17:0]   wgt;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] acc;
	logic [SB-1:0]    new_val;
	logic [SB-1:0]    walk_val;
	logic [RW-1:0]    recip_p;
	logic             emit;

	logic             div_start;
	logic             div_done;
	logic [SUMW-1:0]  div_num;
	logic [VW-1:0]    div_den;
	logic [SUMW-1:0]  div_quo;

	assign out_valid     = out_valid_q;
	assign out_data      = out_q;
	assign stat.idle     = (state_q == S_IDLE);
	assign stat.dividing = (state_q == S_DIVGO) || (state_q == S_DIVW);

	assign hwm_cur    = hwm_q[chs_q];
	assign q_pop      = (state_q == S_IDLE) && q_valid && !out_valid_q;
	assign item_addr  = base_q + AW'(ent_q.bin_idx);
	assign walk_issue = (state_q == S_WALK) && (walk_i_q < n);
	assign ram_re     = ((state_q == S_RD) && ent_q.used) || walk_issue;
	assign ram_raddr  = (state_q == S_WALK) ? (base_q + AW'(walk_i_q)) : item_addr;
	assign ram_we     = (state_q == S_WR);
	assign div_start  = (state_q == S_DIVGO);

	// Blend: new = old + floor((x - old) * (1 - a))
	assign x_val   = SB'(ent_q.magnitude);
	assign old_val = old_ok_q ? ram_rdata : '0;
	assign diff    = $signed({1'b0, x_val}) - $signed({1'b0, old_val});
	assign wgt     = $signed({1'b0, WEIGHT_ONE - {1'b0, smoothing}});
	assign prod    = diff * wgt;
	assign acc     = $signed(PW'(old_s1)) + (prod_s1 >>> 16);
	assign new_val = acc[SB-1:0];

	// Unwritten entries of the store read as zero
	assign walk_val = live_s1 ? ram_rdata : '0;
	assign recip_p  = RW'(n) * RW'(RECIP10);

	assign emit = ((state_q == S_RD) && !ent_q.used && !ent_q.last)
		|| ((state_q == S_WR) && !ent_q.last)
		|| (state_q == S_OUT);

	// Pick the band for the shared divider
	always_comb begin
		case (div_sel_q)
			BAND_LOW: begin
				div_num = low_sum_q;
				div_den = VW'(bass_end_q) + VW'(1);
			end
			BAND_MID: begin
				div_num = mid_sum_q;
				div_den = VW'(mid_end_q - bass_end_q) + VW'(1);
			end
			default: begin
				div_num = high_sum_q;
				div_den = VW'(n - mid_end_q) + VW'(1);
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (q_pop) begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				if (ent_q.used) begin
					state_d = S_MUL;
				end else if (ent_q.last) begin
					state_d = S_PREP;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_MUL: state_d = S_WR;
			S_WR: state_d = ent_q.last ? S_PREP : S_IDLE;
			S_PREP: state_d = S_WALK;
			S_WALK: begin
				if (!walk_issue && !wv_s1) begin
					state_d = S_DIVGO;
				end
			end
			S_DIVGO: state_d = S_DIVW;
			S_DIVW: begin
				if (div_done) begin
					state_d = (div_sel_q == BAND_HIGH) ? S_OUT : S_DIVGO;
				end
			end
			S_OUT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			wv_s1       <= 1'b0;
			walk_i_q    <= '0;
			div_sel_q   <= BAND_LOW;
			for (int c = 0; c < CHANNELS; c++) begin
				hwm_q[c] <= '0;
			end
		end else begin
			state_q <= state_d;
			wv_s1   <= walk_issue;
			// Hold the result until taken
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// Extend the written prefix of the channel
			if (ram_we && (NW'(ent_q.bin_idx) >= hwm_cur)) begin
				hwm_q[chs_q] <= NW'(ent_q.bin_idx) + 1'b1;
			end
			if (state_q == S_PREP) begin
				walk_i_q  <= '0;
				div_sel_q <= BAND_LOW;
			end else if (walk_issue) begin
				walk_i_q <= walk_i_q + 1'b1;
			end else if ((state_q == S_DIVW) && div_done && (div_sel_q != BAND_HIGH)) begin
				div_sel_q <= div_sel_q + 1'b1;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		// Take the queued bin
		if (q_pop) begin
			ent_q  <= q_data;
			chs_q  <= chan_sel(q_data.channel);
			base_q <= AW'(chan_sel(q_data.channel)) * AW'(MAX_BINS);
		end
		// Read the old value, or report an unused bin
		if (state_q == S_RD) begin
			addr_q   <= item_addr;
			old_ok_q <= (NW'(ent_q.bin_idx) < hwm_cur);
			out_q.out_channel <= ent_q.channel;
			out_q.bin_index   <= (ent_q.bin_idx > IDX_W'(IDX_TOP)) ? IDX_TOP
				: ent_q.bin_idx[BIDX_W-1:0];
			out_q.smoothed    <= '0;
			out_q.bin_used    <= 1'b0;
			out_q.bands_valid <= 1'b0;
			out_q.bass        <= '0;
			out_q.mid         <= '0;
			out_q.treble      <= '0;
		end
		if (state_q == S_MUL) begin
			old_s1  <= old_val;
			prod_s1 <= prod;
		end
		if (state_q == S_WR) begin
			out_q.smoothed <= OUT_W'(new_val);
			out_q.bin_used <= 1'b1;
		end
		// Band limits and cleared sums
		if (state_q == S_PREP) begin
			bass_end_q <= NW'(recip_p >> SHIFT_TENTH);
			mid_end_q  <= NW'(recip_p >> SHIFT_TWO_FIFTH);
			low_sum_q  <= '0;
			mid_sum_q  <= '0;
			high_sum_q <= '0;
		end
		// Tag each walk read with its band
		if (walk_issue) begin
			live_s1 <= (walk_i_q < hwm_cur);
			if (walk_i_q < bass_end_q) begin
				band_s1 <= BAND_LOW;
			end else if (walk_i_q < mid_end_q) begin
				band_s1 <= BAND_MID;
			end else begin
				band_s1 <= BAND_HIGH;
			end
		end
		// Accumulate the band sums
		if (wv_s1) begin
			case (band_s1)
				BAND_LOW:  low_sum_q  <= low_sum_q + SUMW'(walk_val);
				BAND_MID:  mid_sum_q  <= mid_sum_q + SUMW'(walk_val);
				default:   high_sum_q <= high_sum_q + SUMW'(walk_val);
			endcase
		end
		// Collect the averages
		if ((state_q == S_DIVW) && div_done) begin
			case (div_sel_q)
				BAND_LOW: out_q.bass   <= OUT_W'(div_quo);
				BAND_MID: out_q.mid    <= OUT_W'(div_quo);
				default:  out_q.treble <= OUT_W'(div_quo);
			endcase
		end
		if (state_q == S_OUT) begin
			out_q.bands_valid <= 1'b1;
		end
	end

	ssba_ram #(
		.WIDTH (SB),
		.DEPTH (CHANNELS * MAX_BINS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (new_val),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ssba_div #(
		.DW (SUMW),
		.VW (VW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

endmodule

`default_nettype wire

FILE: design/spectrum_smoother_band_averager_top.sv
// ----------------------------------------------------------------------------
// spectrum_smoother_band_averager_top
// Smooths per-channel spectrum bins and reports bass, mid and treble averages.
//
//   Port group  Dir  Carries
//   s_axis_*    in   one spectrum bin per word, tlast ends the frame
//   m_axis_*    out  one result word per bin, tlast carries the band averages
//   cfg_*       in   register writes: 0 bin_count, 1 smoothing
//
// The front takes a word per cycle while its 4-entry queue has room.
// The back steps a used bin through pop, store read, multiply and write, and an
// unused one through pop and store read; it pops only once its word is taken.
// A frame end adds a store walk over the n active bins and one run per band of
// the shared bit-serial divider, SUMW = SAMPLE_BITS + log2(MAX_BINS).
// Reset needs no clearing pass: a per-channel written-prefix count makes
// never-written store entries read as zero. A waiting result stalls the back; input stalls once the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

`include "spectrum_smoother_band_averager_top_macros.svh"

module spectrum_smoother_band_averager_top #(
	parameter int MAX_BINS    = 1024,
	parameter int CHANNELS    = 4,
	parameter int SAMPLE_BITS = 24
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [ssba_pkg::MAG_W-1:0]        s_axis_tdata,  // [23:0] magnitude
	input  wire logic [ssba_pkg::CH_W-1:0]         s_axis_tuser,  // [1:0] channel
	input  wire logic                              s_axis_tlast,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// [9:0] bin_index, [33:10] smoothed, [57:34] bass, [81:58] mid,
	// [105:82] treble, [111:106] zero
	output logic      [111:0]                      m_axis_tdata,
	output logic      [2:0]                        m_axis_tuser,  // [1:0] out_channel, [2] bin_used
	output logic                                   m_axis_tlast,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [ssba_pkg::CFG_IX_W-1:0]     cfg_index,
	input  wire logic [ssba_pkg::CFG_D_W-1:0]      cfg_data
);

	import ssba_pkg::*;

	localparam int NW = $clog2(MAX_BINS + 1);
	localparam int CW = (NW > BC_W) ? NW : BC_W;

	logic [BC_W-1:0] bin_count_q;
	logic [SM_W-1:0] smoothing_q;
	logic [NW-1:0]   n;
	logic            q_full;
	logic            q_push;
	q_entry_t        q_in;
	logic            q_pop;
	logic            q_valid;
	q_entry_t        q_out;
	result_t         res;
	back_stat_t      bk_stat;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_count_q <= BIN_COUNT_RST;
			smoothing_q <= SMOOTHING_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BIN_COUNT: bin_count_q <= cfg_data[BC_W-1:0];
				CFG_SMOOTHING: smoothing_q <= cfg_data[SM_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the active bin count to MAX_BINS, the store depth of one channel
	assign n = (CW'(bin_count_q) > CW'(MAX_BINS)) ? NW'(MAX_BINS) : NW'(bin_count_q);

	ssba_front #(
		.MAX_BINS (MAX_BINS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.n            (n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_channel   (s_axis_tuser),
		.in_magnitude (s_axis_tdata),
		.in_last      (s_axis_tlast),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_in)
	);

	ssba_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_out)
	);

	ssba_back #(
		.MAX_BINS    (MAX_BINS),
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.n         (n),
		.smoothing (smoothing_q),
		.q_valid   (q_valid),
		.q_data    (q_out),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (res),
		.stat      (bk_stat)
	);

	// Pack the result word
	assign m_axis_tdata = {6'b000000, res.treble, res.mid, res.bass, res.smoothed,
		res.bin_index};
	assign m_axis_tuser = {res.bin_used, res.out_channel};
	assign m_axis_tlast = res.bands_valid;

	// Checks
	`SSBA_CHK_NOW(a_pop_has_entry, clk, arst_n, q_pop, q_valid)
	`SSBA_CHK_NEXT(a_pop_leaves_idle, clk, arst_n, q_pop, !bk_stat.idle)
	`SSBA_CHK_NOW(a_full_stalls_input, clk, arst_n, q_full, !s_axis_tready)
	`SSBA_CHK_NOW(a_unused_reads_zero, clk, arst_n,
		m_axis_tvalid && !m_axis_tuser[2], m_axis_tdata[33:10] == 24'd0)
	`SSBA_CHK_NOW(a_divide_slot_free, clk, arst_n, bk_stat.dividing, !m_axis_tvalid)

endmodule

`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the spectrum smoother band averager. Frames of bins
// stream in over the slave side and every result word is checked against a
// bit-exact smoothing and band-average predictor kept in a scoreboard class.
// The run covers directed corner frames, a long frame that saturates the bin
// index, and random frames over many register settings and handshake gaps.
// ----------------------------------------------------------------------------
module tb;
	import ssba_pkg::*;

	localparam int MAX_BINS    = 1024;
	localparam int QUIET_LIMIT = 10000;
	localparam int TAIL_CYCLES = 200;
	localparam int PHASE_BINS  = 190;
	localparam int LONG_FRAME  = 1100;

	// Predicts each result word from the accepted bins and checks the output
	class band_average_tracker;
		bit [OUT_W-1:0] bin_store [4][MAX_BINS];
		bit [BC_W-1:0]  bin_count_reg;
		bit [SM_W-1:0]  smoothing_reg;
		bit [IDX_W-1:0] next_bin;
		bit [CH_W-1:0]  frame_ch;
		result_t        expected_words [$];
		int             errors;

		function new();
			bin_count_reg = BIN_COUNT_RST;
			smoothing_reg = SMOOTHING_RST;
			next_bin      = '0;
			frame_ch      = '0;
			errors        = 0;
		endfunction

		function void write_reg(logic [CFG_IX_W-1:0] idx, logic [CFG_D_W-1:0] data);
			if (idx == CFG_BIN_COUNT)
				bin_count_reg = data[BC_W-1:0];
			else if (idx == CFG_SMOOTHING)
				smoothing_reg = data[SM_W-1:0];
		endfunction

		function void take_bin(bit [CH_W-1:0] ch, bit [MAG_W-1:0] mag, bit last);
			result_t         r;
			int unsigned     n;
			int unsigned     bass_end;
			int unsigned     mid_end;
			longint unsigned acc;
			longint unsigned low_sum;
			longint unsigned mid_sum;
			longint unsigned high_sum;
			n = (bin_count_reg > MAX_BINS) ? MAX_BINS : bin_count_reg;
			// latch the channel on the first bin of a frame
			if (next_bin == 0)
				frame_ch = ch;
			r = '0;
			r.out_channel = frame_ch;
			r.bin_index   = (next_bin > IDX_TOP) ? IDX_TOP : next_bin[BIDX_W-1:0];
			// blend the bin into the store while inside the active range
			if (next_bin < n) begin
				acc = 64'(bin_store[frame_ch][next_bin]) * 64'(smoothing_reg)
					+ 64'(mag) * (64'(WEIGHT_ONE) - 64'(smoothing_reg));
				bin_store[frame_ch][next_bin] = acc[39:16];
				r.smoothed = acc[39:16];
				r.bin_used = 1'b1;
			end
			// walk the whole active store of the channel at frame end
			if (last) begin
				bass_end = n / 10;
				mid_end  = (2 * n) / 5;
				low_sum  = 0;
				mid_sum  = 0;
				high_sum = 0;
				for (int i = 0; i < n; i++) begin
					if (i < bass_end)
						low_sum += bin_store[frame_ch][i];
					else if (i < mid_end)
						mid_sum += bin_store[frame_ch][i];
					else
						high_sum += bin_store[frame_ch][i];
				end
				r.bands_valid = 1'b1;
				r.bass   = OUT_W'(low_sum / (64'(bass_end) + 1));
				r.mid    = OUT_W'(mid_sum / (64'(mid_end - bass_end) + 1));
				r.treble = OUT_W'(high_sum / (64'(n - mid_end) + 1));
				next_bin = '0;
			end else if (next_bin < CNT_TOP) begin
				next_bin++;
			end
			expected_words.push_back(r);
		endfunction

		function void cmp(string field, longint unsigned exp_v, longint unsigned got_v);
			if (exp_v != got_v) begin
				$error("%s: expected %0d, got %0d", field, exp_v, got_v);
				errors++;
			end
		endfunction

		function void check_word(result_t got);
			result_t e;
			if (expected_words.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
				return;
			end
			e = expected_words.pop_front();
			cmp("out_channel", e.out_channel, got.out_channel);
			cmp("bin_index", e.bin_index, got.bin_index);
			cmp("smoothed", e.smoothed, got.smoothed);
			cmp("bin_used", e.bin_used, got.bin_used);
			cmp("bands_valid", e.bands_valid, got.bands_valid);
			cmp("bass", e.bass, got.bass);
			cmp("mid", e.mid, got.mid);
			cmp("treble", e.treble, got.treble);
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                s_axis_tvalid  = 1'b0;
	logic                s_axis_tready;
	logic [MAG_W-1:0]    s_axis_tdata   = '0;
	logic [CH_W-1:0]     s_axis_tuser   = '0;
	logic                s_axis_tlast   = 1'b0;
	logic                m_axis_tvalid;
	logic                m_axis_tready  = 1'b0;
	logic [111:0]        m_axis_tdata;
	logic [2:0]          m_axis_tuser;
	logic                m_axis_tlast;
	logic                cfg_valid      = 1'b0;
	logic                cfg_ready;
	logic [CFG_IX_W-1:0] cfg_index      = '0;
	logic [CFG_D_W-1:0]  cfg_data       = '0;

	band_average_tracker tracker = new();
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int sink_hold      = 0;
	int quiet_cycles   = 0;

	spectrum_smoother_band_averager_top dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Drive one bin, idling first at the current sender rate
	task automatic push_bin(bit [CH_W-1:0] ch, bit [MAG_W-1:0] mag, bit last);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= mag;
		s_axis_tuser  <= ch;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		tracker.take_bin(ch, mag, last);
	endtask

	function automatic bit [MAG_W-1:0] rand_mag();
		case ($urandom_range(3))
			0: return MAG_W'($urandom_range(255));
			1: return {MAG_W{1'b1}} - MAG_W'($urandom_range(255));
			default: return MAG_W'($urandom());
		endcase
	endfunction

	task automatic send_frame(int len, bit [CH_W-1:0] ch);
		for (int k = 0; k < len; k++)
			push_bin((k == 0) ? ch : CH_W'($urandom_range(3)), rand_mag(), k == len - 1);
	endtask

	// Stop offering bins and wait for every outstanding word
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	// Write both registers back to back, holding valid across the pair
	task automatic set_regs(int unsigned bc, int unsigned sm);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_BIN_COUNT;
		cfg_data  <= CFG_D_W'(bc);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tracker.write_reg(CFG_BIN_COUNT, CFG_D_W'(bc));
		cfg_index <= CFG_SMOOTHING;
		cfg_data  <= CFG_D_W'(sm);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tracker.write_reg(CFG_SMOOTHING, CFG_D_W'(sm));
		cfg_valid <= 1'b0;
	endtask

	function automatic int unsigned pick_bin_count();
		case ($urandom_range(19))
			0: return 0;
			1: return 1;
			2: return MAX_BINS;
			3: return $urandom_range(MAX_BINS + 1, 2047);
			4, 5: return $urandom_range(65, 300);
			default: return $urandom_range(2, 40);
		endcase
	endfunction

	function automatic int unsigned pick_smoothing();
		case ($urandom_range(5))
			0: return 0;
			1: return 65535;
			2: return 32768;
			default: return $urandom_range(65535);
		endcase
	endfunction

	// Mostly full frames on small stores, short ones where the store is large
	function automatic int frame_len(int unsigned bc);
		int unsigned n;
		n = (bc > MAX_BINS) ? MAX_BINS : bc;
		if (n == 0)
			return $urandom_range(1, 6);
		if (n > 64)
			return $urandom_range(1, 48);
		case ($urandom_range(3))
			0: return $urandom_range(1, n);
			1: return n + $urandom_range(1, 4);
			default: return n;
		endcase
	endfunction

	task automatic run_phase(int src_pct, int sink_pct, int target);
		int sent;
		int frames;
		int len;
		sent   = 0;
		frames = 0;
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		while (sent < target) begin
			if (frames % 3 == 0) begin
				drain();
				set_regs(pick_bin_count(), pick_smoothing());
			end
			len = frame_len(tracker.bin_count_reg);
			send_frame(len, CH_W'($urandom_range(3)));
			sent += len;
			frames++;
		end
		drain();
	endtask

	// Accept result words, stalling at random or for a requested hold
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			if (sink_hold != 0) begin
				m_axis_tready <= 1'b0;
				sink_hold--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
			end
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				tracker.check_word('{
					out_channel: m_axis_tuser[1:0],
					bin_index:   m_axis_tdata[9:0],
					smoothed:    m_axis_tdata[33:10],
					bin_used:    m_axis_tuser[2],
					bands_valid: m_axis_tlast,
					bass:        m_axis_tdata[57:34],
					mid:         m_axis_tdata[81:58],
					treble:      m_axis_tdata[105:82]});
		end
	end

	// End the run when no word moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: magnitude extremes, channel ignored after the first bin
		push_bin(2'd0, 24'd0, 1'b0);
		push_bin(2'd0, 24'hFFFFFF, 1'b0);
		push_bin(2'd3, 24'hFFFFFF, 1'b0);
		push_bin(2'd1, 24'h123456, 1'b1);
		drain();
		// one active bin and no smoothing; later bins fall past the bin count
		set_regs(1, 0);
		push_bin(2'd3, 24'hFFFFFF, 1'b0);
		push_bin(2'd0, 24'd5, 1'b0);
		push_bin(2'd0, 24'd7, 1'b1);
		drain();
		// zero bin count: nothing used, all averages zero
		set_regs(0, 65535);
		push_bin(2'd1, 24'hAAAAAA, 1'b0);
		push_bin(2'd1, 24'h555555, 1'b1);
		drain();
		// bin count above the store size is clipped to it
		set_regs(2047, 32768);
		push_bin(2'd2, 24'hFFFFFF, 1'b0);
		push_bin(2'd2, 24'h800000, 1'b0);
		push_bin(2'd2, 24'd1, 1'b1);
		drain();
		// register change in the middle of a frame
		set_regs(10, 0);
		push_bin(2'd1, 24'h00FF00, 1'b0);
		push_bin(2'd1, 24'hFF00FF, 1'b0);
		push_bin(2'd1, 24'h0F0F0F, 1'b0);
		drain();
		set_regs(2, 65535);
		push_bin(2'd1, 24'hF0F0F0, 1'b0);
		push_bin(2'd1, 24'h000001, 1'b1);
		drain();
		// single-bin frame
		set_regs(20, 1);
		push_bin(2'd3, 24'hFFFFFF, 1'b1);
		drain();

		// long frame: bin index saturates past the store size
		set_regs(MAX_BINS, pick_smoothing());
		send_frame(LONG_FRAME, CH_W'($urandom_range(3)));
		drain();

		// hold the receiver off while bins keep coming, then run random phases
		sink_hold = 400;
		run_phase(0, 0, PHASE_BINS);
		run_phase(74, 0, PHASE_BINS);
		run_phase(0, 74, PHASE_BINS);
		run_phase(9, 9, PHASE_BINS);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule
